[rtl/core/swm_pkg.sv]
package swm_pkg;

  // Window depth and sample width
  localparam int WIN_MAX  = 64;
  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;

  // Index of one cell, and a count that can hold WIN_MAX itself
  localparam int IDX_W = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int CNT_W = $clog2(WIN_MAX + 1);

  // Contents of one sorted cell
  typedef struct packed {
    logic                       valid;
    logic [IDX_W-1:0]           age;    // 0 = newest sample
    logic signed [SAMPLE_W-1:0] value;
  } cell_t;

  // Command broadcast to every cell in the same cycle
  typedef struct packed {
    logic                       ins;      // insert value in sorted place
    logic                       restart;  // empty the row before the insert
    logic                       drop;     // remove the cell of age drop_age
    logic [IDX_W-1:0]           drop_age;
    logic signed [SAMPLE_W-1:0] value;
  } cell_op_t;

endpackage

[rtl/core/swm_cell.sv]
module swm_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  swm_pkg::cell_op_t op_i,
  input  swm_pkg::cell_t   left_i,       // neighbor on the lower side
  input  logic             left_le_i,    // lower neighbor keeps its place on insert
  input  logic             left_gone_i,  // dropped cell lies at or below lower neighbor
  input  swm_pkg::cell_t   right_i,      // neighbor on the upper side
  output swm_pkg::cell_t   cell_o,
  output logic             le_o,
  output logic             gone_o
);
  import swm_pkg::*;

  logic                       valid_q, valid_d;
  logic [IDX_W-1:0]           age_q, age_d;
  logic signed [SAMPLE_W-1:0] value_q, value_d;
  logic                       kill;

  // Visible state; a restart empties the row for this insert
  always_comb begin
    cell_o.valid = valid_q & ~(op_i.ins & op_i.restart);
    cell_o.age   = age_q;
    cell_o.value = value_q;
  end

  // Insert: cells at or below the new value stay, the next one takes it
  assign le_o = cell_o.valid && (value_q <= op_i.value);

  // Drop: the cell of the given age and everything above it move down
  assign kill   = cell_o.valid && (age_q == op_i.drop_age);
  assign gone_o = kill | left_gone_i;

  always_comb begin
    valid_d = cell_o.valid;
    age_d   = age_q;
    value_d = value_q;
    if (op_i.ins) begin
      if (le_o) begin
        age_d = age_q + 1'b1;
      end else if (left_le_i) begin
        valid_d = 1'b1;
        age_d   = '0;
        value_d = op_i.value;
      end else begin
        valid_d = left_i.valid;
        age_d   = left_i.age + 1'b1;
        value_d = left_i.value;
      end
    end else if (op_i.drop && gone_o) begin
      valid_d = right_i.valid;
      age_d   = right_i.age;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q   <= age_d;
    value_q <= value_d;
  end

endmodule

[rtl/core/swm_chain.sv]
module swm_chain (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  swm_pkg::cell_op_t                  op_i,
  input  logic [swm_pkg::IDX_W-1:0]          sel_i,
  output logic signed [swm_pkg::SAMPLE_W-1:0] sel_value_o
);
  import swm_pkg::*;

  cell_t cells [WIN_MAX];
  logic  le    [WIN_MAX];
  logic  gone  [WIN_MAX];

  // Row of cells kept in ascending order; among equal values the oldest
  // sits lowest
  for (genvar i = 0; i < WIN_MAX; i++) begin : g_cell
    cell_t left_c, right_c;
    logic  left_le, left_gone;

    if (i == 0) begin : g_lo
      assign left_c    = '0;
      assign left_le   = 1'b1;
      assign left_gone = 1'b0;
    end else begin : g_mid
      assign left_c    = cells[i-1];
      assign left_le   = le[i-1];
      assign left_gone = gone[i-1];
    end

    if (i == WIN_MAX - 1) begin : g_hi
      assign right_c = '0;
    end else begin : g_nx
      assign right_c = cells[i+1];
    end

    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op_i),
      .left_i      (left_c),
      .left_le_i   (left_le),
      .left_gone_i (left_gone),
      .right_i     (right_c),
      .cell_o      (cells[i]),
      .le_o        (le[i]),
      .gone_o      (gone[i])
    );
  end

  // Rank select for the median
  assign sel_value_o = cells[sel_i].value;

endmodule

[rtl/core/sliding_window_median.sv]
// Channel   Direction  Handshake                     Word
// ------    ---------  ----------------------------  -------------------------
// in        input      in_valid_i / in_stall_o       sample_i, restart_i
// out       output     out_valid_o / out_stall_i     median_o
// cfg       input      cfg_we_i                      cfg_wdata_i (window size)
//
// Each sample is first inserted into the sorted cell row. The retire step then
// drops any surplus samples left by a window shrunk mid-sequence and, once the
// window is full, emits the median and retires the oldest sample.
// Reset empties the row and sets the window size to 1.
// A result waiting on out_stall_i holds the block in its retire step; the
// next sample is taken while the last result still waits.
module sliding_window_median (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [swm_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [swm_pkg::SAMPLE_W-1:0] median_o
);
  import swm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_TRIM
  } state_e;

  state_e                     state_q, state_d;
  logic [CFG_W-1:0]           win_size_q;
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] median_q, median_d;
  logic [CNT_W-1:0]           k_eff;
  logic [CNT_W-1:0]           k_less1;
  logic [IDX_W-1:0]           med_idx;
  logic signed [SAMPLE_W-1:0] med_value;
  logic                       in_take;
  logic                       out_free;
  cell_op_t                   op;

  // Effective window size, clamped to 1..WIN_MAX
  always_comb begin
    if (32'(win_size_q) == 32'd0) begin
      k_eff = CNT_W'(1);
    end else if (32'(win_size_q) > 32'(WIN_MAX)) begin
      k_eff = CNT_W'(WIN_MAX);
    end else begin
      k_eff = CNT_W'(win_size_q);
    end
  end

  // Lower median rank
  assign k_less1 = k_eff - 1'b1;
  assign med_idx = IDX_W'(k_less1 >> 1);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  // Sequencer: insert, then retire surplus samples, then emit and retire once the window is full
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    median_d    = median_q;
    op          = '0;
    op.value    = sample_i;
    op.drop_age = IDX_W'(count_q - 1'b1);
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          op.ins     = 1'b1;
          op.restart = restart_i;
          count_d    = (restart_i ? '0 : count_q) + 1'b1;
          state_d    = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (count_q > k_eff) begin
          op.drop = 1'b1;
          count_d = count_q - 1'b1;
        end else if (count_q == k_eff) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            median_d    = med_value;
            op.drop     = 1'b1;
            count_d     = count_q - 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      median_q    <= '0;
      win_size_q  <= CFG_W'(1);
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      median_q    <= median_d;
      if (cfg_we_i) begin
        win_size_q <= cfg_wdata_i;
      end
    end
  end

  swm_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .sel_i       (med_idx),
    .sel_value_o (med_value)
  );

endmodule

[dv/tb_sliding_window_median.sv]
`timescale 1ns / 1ps

module tb_sliding_window_median;
  import swm_pkg::*;

  localparam int ITEM_TARGET  = 1500;
  localparam int SETTLE_TICKS = 80;    // covers insert, retire and surplus retires
  localparam int HOLD_TICKS   = 400;
  localparam int QUIET_TAIL   = 150;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       restart;
  } sample_word_t;

  // DUT ports
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]           cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       restart_i   = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] median_o;

  // Stimulus and predictor state
  sample_word_t               pending_words[$];
  sample_word_t               next_word;
  logic signed [SAMPLE_W-1:0] arrival_q[$];    // window in arrival order
  logic signed [SAMPLE_W-1:0] sorted_q[$];     // same window, ascending
  logic signed [SAMPLE_W-1:0] median_exp_q[$];
  logic signed [SAMPLE_W-1:0] median_exp;
  logic [CFG_W-1:0]           window_cfg = 7'd1;

  logic word_taken = 1'b0;
  logic quiet_tail = 1'b0;
  logic hold_arm   = 1'b0;
  logic hold_done  = 1'b0;
  int   send_gap   = 0;
  int   stall_left = 0;
  int   hold_left  = 0;
  int   words_pushed = 0;
  int   words_in     = 0;
  int   medians_checked = 0;
  int   mismatch_count  = 0;
  int   settings_used   = 0;

  sliding_window_median u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .median_o    (median_o)
  );

  always #10 clk_i = ~clk_i;

  // Retire the oldest sample; one equal entry leaves the sorted window
  function automatic void retire_oldest();
    logic signed [SAMPLE_W-1:0] gone;
    int pos;
    gone = arrival_q.pop_front();
    pos  = 0;
    while (pos < sorted_q.size() && sorted_q[pos] != gone) pos++;
    if (pos < sorted_q.size()) sorted_q.delete(pos);
  endfunction

  // Lower median of the window ending at this word, if the window is full
  function automatic void predict_median(logic signed [SAMPLE_W-1:0] smp, logic restart);
    int k;
    int pos;
    k = (window_cfg == 0) ? 1 : (window_cfg > WIN_MAX) ? WIN_MAX : int'(window_cfg);
    if (restart) begin
      arrival_q.delete();
      sorted_q.delete();
    end
    pos = 0;
    while (pos < sorted_q.size() && sorted_q[pos] <= smp) pos++;
    sorted_q.insert(pos, smp);
    arrival_q.insert(arrival_q.size(), smp);
    // a shrunk window sheds its surplus before the median
    while (arrival_q.size() > k) retire_oldest();
    if (arrival_q.size() == k) begin
      median_exp_q.insert(median_exp_q.size(), sorted_q[(k - 1) / 2]);
      retire_oldest();
    end
  endfunction

  function automatic void push_word(logic signed [SAMPLE_W-1:0] smp, logic restart);
    sample_word_t w;
    w.smp     = smp;
    w.restart = restart;
    pending_words.insert(pending_words.size(), w);
    words_pushed++;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = S_MIN;
      1:       v = S_MAX;
      2, 3:    v = int'($urandom_range(0, 8)) - 4;   // narrow range, many ties
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Wait until every word is taken and every median has come out
  task automatic settle_idle();
    while (pending_words.size() != 0 || in_valid_i || median_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_window(logic [CFG_W-1:0] size);
    settle_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = size;
    window_cfg  = size;
    settings_used++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Sender: one word at a time, random gaps between words
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || word_taken) begin
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
        send_gap   <= $urandom_range(0, 16);
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_word   = pending_words.pop_front();
        in_valid_i <= 1'b1;
        sample_i   <= next_word.smp;
        restart_i  <= next_word.restart;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, and one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_arm && !hold_done) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_TICKS - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
      stall_left  <= $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check each median leaving, then predict from each word entering
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (median_exp_q.size() == 0) begin
          $display("%0t: median with none expected, actual %0d", $time, median_o);
          mismatch_count++;
        end else begin
          median_exp = median_exp_q.pop_front();
          medians_checked++;
          if (median_o !== median_exp) begin
            $display("%0t: median mismatch, expected %0d, actual %0d",
                     $time, median_exp, median_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_median(sample_i, restart_i);
        words_in++;
      end
      word_taken <= in_valid_i && !in_stall_o;
    end
  end

  initial begin : stimulus
    int phase;
    int k;
    int count;
    int size;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Window of one after reset: extremes pass straight through
    push_word(S_MIN, 1'b0);
    push_word(S_MAX, 1'b1);
    push_word('0, 1'b0);
    push_word(-1, 1'b0);
    // Size zero behaves as one
    write_window(7'd0);
    push_word(123, 1'b1);
    push_word(-7, 1'b0);
    // Even window, lower median, repeated values
    write_window(7'd4);
    push_word(5, 1'b1);
    push_word(S_MIN, 1'b0);
    push_word(5, 1'b0);
    push_word(S_MAX, 1'b0);
    push_word(5, 1'b0);
    // Restart in the middle of a filling window
    write_window(7'd3);
    push_word(9, 1'b1);
    push_word(2, 1'b0);
    push_word(-4, 1'b1);
    push_word(-4, 1'b0);
    push_word(-4, 1'b0);
    // Partial window of five, then shrink to two
    write_window(7'd5);
    push_word(1, 1'b1);
    push_word(2, 1'b0);
    push_word(3, 1'b0);
    push_word(4, 1'b0);
    write_window(7'd2);
    push_word(10, 1'b0);
    // Grow back to four; output waits for the window to refill
    write_window(7'd4);
    push_word(-6, 1'b0);
    push_word(8, 1'b0);
    push_word(8, 1'b0);

    // Random settings, each with a random stream
    phase = 0;
    while (words_pushed < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       size = $urandom_range(9, WIN_MAX);
        1:       size = $urandom_range(WIN_MAX + 1, 127);
        2:       size = 0;
        default: size = $urandom_range(1, 8);
      endcase
      if (phase == 0) size = WIN_MAX;
      if (phase == 1) size = 127;
      if (phase == 3) size = 2;
      write_window(size[CFG_W-1:0]);
      k = (size == 0) ? 1 : (size > WIN_MAX) ? WIN_MAX : size;
      count = k + $urandom_range(4, 60);
      if (phase == 3) begin
        count    = 120;
        hold_arm = 1'b1;
      end
      if (words_pushed + count > ITEM_TARGET - QUIET_TAIL) quiet_tail = 1'b1;
      push_word(rand_sample(), $urandom_range(0, 2) == 0);
      for (int i = 1; i < count; i++)
        push_word(rand_sample(), $urandom_range(0, 39) == 0);
      phase++;
    end

    settle_idle();
    $display("%0d samples taken and %0d medians checked under %0d window settings,",
             words_in, medians_checked, settings_used);
    $display("sizes 0, 64 and 127 included, shrink, grow, restarts and one long output hold.");
    if (mismatch_count == 0 && median_exp_q.size() == 0) begin
      $display("sliding_window_median regression: pass");
    end else begin
      $display("sliding_window_median regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("sliding_window_median regression: fail");
    $finish;
  end

endmodule

[sliding_window_median.f]
rtl/core/swm_pkg.sv
rtl/core/swm_cell.sv
rtl/core/swm_chain.sv
rtl/core/sliding_window_median.sv
dv/tb_sliding_window_median.sv
